FILE: hdl/nev_pkg.sv
// nev_pkg: shared types and constants for the neville interpolator core
// holds the cell control struct, fsm state type, request codes and default sizes
// no dependencies
package nev_pkg;

    // field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int NP_W     = 5;
    // magnitude width of an abscissa difference (two 32-bit values)
    localparam int H_W      = DATA_W + 1;

    localparam int MAX_POINTS_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [NP_W-1:0] NP_RESET = NP_W'(4);

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic probe_load;
        logic probe_shift;
        logic tab_init;
        logic op_start;
        logic mul_step;
        logic div_step;
        logic commit;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP,
        ST_SEARCH,
        ST_YINIT,
        ST_SHIFT,
        ST_OPST,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_PICK,
        ST_DONE
    } st_t;

endpackage

FILE: hdl/neville_polynomial_interpolator_core.sv
// neville_polynomial_interpolator_core: top level, sequencer and chain of tableau cells
// depends on nev_pkg, nev_cell and nev_muldiv
//
//  channel  | signals                                            | handshake
//  ---------+----------------------------------------------------+-------------------------
//  request  | req_type, point_index, x_value, y_value            | start high, busy low
//  config   | cfg_data                                           | cfg_valid and cfg_ready
//  result   | estimate, error_estimate, divide_fault             | result_valid, one cycle
//
// a load beat leaves the core idle and gives no result
// a query runs a duplicate scan and then a nearest search over the n points in use;
// then every tableau column runs all cells in parallel through a bit-serial multiply
// and divide
// reset clears the sequencer and sets num_points to 4; table entries stay unwritten
// config is held off while a query runs or a request is offered
// the receiver cannot stall: result_valid is high for exactly one cycle
module neville_polynomial_interpolator_core #(
    parameter int MAX_POINTS  = nev_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = nev_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [nev_pkg::IDX_W-1:0]         point_index,
    input  logic signed [nev_pkg::DATA_W-1:0] x_value,
    input  logic signed [nev_pkg::DATA_W-1:0] y_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nev_pkg::NP_W-1:0]          cfg_data,
    output logic                              result_valid,
    output logic signed [nev_pkg::DATA_W-1:0] estimate,
    output logic signed [nev_pkg::DATA_W-1:0] error_estimate,
    output logic                              divide_fault
);
    import nev_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int MP  = MAX_POINTS;
    localparam int IW  = $clog2(MP);
    localparam int NW  = $clog2(MP + 1);
    localparam int PW  = VW + H_W - 1;
    localparam int CM  = (PW > MP) ? PW : MP;
    localparam int CW  = $clog2(CM);
    localparam int EO  = (VW > DATA_W) ? VW : DATA_W;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [EO-1:0] OMAX =
        signed'({{(EO-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    localparam logic signed [EO-1:0] OMIN = ~OMAX;

    st_t                  state_reg, state_next;
    logic [NP_W-1:0]      num_points_reg;
    logic                 fault_reg, fault_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        m_reg, m_next;
    logic [IW-1:0]        p_reg, p_next;
    logic [H_W-1:0]       best_reg, best_next;
    logic signed [VW-1:0] y_reg, y_next;
    logic signed [VW-1:0] dy_reg, dy_next;
    logic signed [DATA_W-1:0] qx_reg, qx_next;

    cell_ctrl_t           ctrl;
    logic                 accept;
    logic [NW-1:0]        n_eff;
    logic                 hit_any;

    logic signed [DATA_W-1:0] xa_arr    [MP];
    logic signed [DATA_W-1:0] probe_arr [MP];
    logic [MP-1:0]            probe_v_arr;
    logic signed [VW-1:0]     c_arr     [MP];
    logic signed [VW-1:0]     d_arr     [MP];
    logic [MP-1:0]            hit_arr;
    logic [MP-1:0]            valid_arr;

    logic signed [DATA_W-1:0] xa_sel;
    logic signed [H_W-1:0]    diff;
    logic [H_W-1:0]           diff_mag;
    logic [IW-1:0]            p_dec;
    logic                     go_up;
    logic signed [VW-1:0]     dy_sel;
    logic signed [VW:0]       y_sum;
    logic signed [EO-1:0]     y_e;
    logic signed [EO-1:0]     dy_e;

    assign accept    = start & ~busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = ~busy & ~start;

    // effective point count, zero acts as one and a count above MAX_POINTS acts as MAX_POINTS
    always_comb
    begin
        if (num_points_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(num_points_reg) > MP)
        begin
            n_eff = NW'(MP);
        end
        else
        begin
            n_eff = NW'(num_points_reg);
        end
    end

    // chain of cells
    for (genvar i = 0; i < MP; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] probe_nb;
        logic                     probe_v_nb;
        logic signed [VW-1:0]     c_nb;

        if (i == MP - 1)
        begin : g_end
            assign probe_nb   = '0;
            assign probe_v_nb = 1'b0;
            assign c_nb       = '0;
        end
        else
        begin : g_mid
            assign probe_nb   = probe_arr[i+1];
            assign probe_v_nb = probe_v_arr[i+1];
            assign c_nb       = c_arr[i+1];
        end

        assign valid_arr[i] = (i < int'(n_eff));

        nev_cell #(.VW(VW)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_en      (accept && (req_type == REQ_LOAD) && (int'(point_index) == i)),
            .wr_x       (x_value),
            .wr_y       (y_value),
            .qx         (qx_reg),
            .cell_valid (valid_arr[i]),
            .probe_in   (probe_nb),
            .probe_vin  (probe_v_nb),
            .c_in       (c_nb),
            .xa         (xa_arr[i]),
            .probe      (probe_arr[i]),
            .probe_v    (probe_v_arr[i]),
            .c_out      (c_arr[i]),
            .d_out      (d_arr[i]),
            .hit        (hit_arr[i])
        );
    end

    assign hit_any = |hit_arr;

    // nearest search and column pick datapath
    always_comb
    begin
        xa_sel   = xa_arr[cnt_reg[IW-1:0]];
        diff     = {xa_sel[DATA_W-1], xa_sel} - {qx_reg[DATA_W-1], qx_reg};
        diff_mag = diff[H_W-1] ? -diff : diff;
        p_dec    = p_reg - IW'(1);
        go_up    = ({1'b0, p_reg, 1'b0} < (IW+2)'(n_eff - m_reg));
        dy_sel   = go_up ? c_arr[p_reg] : d_arr[p_dec];
        y_sum    = {y_reg[VW-1], y_reg} + {dy_sel[VW-1], dy_sel};
    end

    // sequencer: next state, cell control and datapath updates
    always_comb
    begin
        state_next = state_reg;
        fault_next = fault_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        best_next  = best_reg;
        y_next     = y_reg;
        dy_next    = dy_reg;
        qx_next    = qx_reg;
        ctrl       = '0;
        result_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (req_type == REQ_EVAL))
                begin
                    qx_next         = x_value;
                    ctrl.probe_load = 1'b1;
                    cnt_next        = '0;
                    fault_next      = 1'b0;
                    state_next      = ST_DUP;
                end
            end
            ST_DUP:
            begin
                ctrl.probe_shift = 1'b1;
                fault_next = fault_reg | (hit_any & (cnt_reg != '0));
                if (cnt_reg == CW'(n_eff - NW'(1)))
                begin
                    if (fault_next)
                    begin
                        y_next     = '0;
                        dy_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ctrl.probe_shift = 1'b0;
                        ctrl.probe_load  = 1'b1;
                        ctrl.tab_init    = 1'b1;
                        cnt_next         = '0;
                        state_next       = ST_SEARCH;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_SEARCH:
            begin
                if ((cnt_reg == '0) || (diff_mag < best_reg))
                begin
                    best_next = diff_mag;
                    p_next    = cnt_reg[IW-1:0];
                end
                if (cnt_reg == CW'(n_eff - NW'(1)))
                begin
                    state_next = ST_YINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_YINIT:
            begin
                y_next  = c_arr[p_reg];
                dy_next = '0;
                m_next  = NW'(1);
                state_next = (n_eff == NW'(1)) ? ST_DONE : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctrl.probe_shift = 1'b1;
                state_next       = ST_OPST;
            end
            ST_OPST:
            begin
                ctrl.op_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                if (cnt_reg == CW'(H_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == CW'(PW - 1))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_COMMIT:
            begin
                ctrl.commit = 1'b1;
                state_next  = ST_PICK;
            end
            ST_PICK:
            begin
                if (!go_up)
                begin
                    p_next = p_dec;
                end
                dy_next = dy_sel;
                if (y_sum[VW] != y_sum[VW-1])
                begin
                    y_next = y_sum[VW] ? VMIN : VMAX;
                end
                else
                begin
                    y_next = y_sum[VW-1:0];
                end
                if (m_reg == n_eff - NW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    m_next     = m_reg + NW'(1);
                    state_next = ST_SHIFT;
                end
            end
            ST_DONE:
            begin
                result_valid = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_points_reg <= NP_RESET;
            fault_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fault_reg <= fault_next;
            if (cfg_valid && cfg_ready)
            begin
                num_points_reg <= cfg_data;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        m_reg    <= m_next;
        p_reg    <= p_next;
        best_reg <= best_next;
        y_reg    <= y_next;
        dy_reg   <= dy_next;
        qx_reg   <= qx_next;
    end

    // result saturated to the port width
    always_comb
    begin
        y_e  = EO'(y_reg);
        dy_e = EO'(dy_reg);
        if (y_e > OMAX)
        begin
            estimate = OMAX[DATA_W-1:0];
        end
        else if (y_e < OMIN)
        begin
            estimate = OMIN[DATA_W-1:0];
        end
        else
        begin
            estimate = y_e[DATA_W-1:0];
        end
        if (dy_e > OMAX)
        begin
            error_estimate = OMAX[DATA_W-1:0];
        end
        else if (dy_e < OMIN)
        begin
            error_estimate = OMIN[DATA_W-1:0];
        end
        else
        begin
            error_estimate = dy_e[DATA_W-1:0];
        end
    end

    assign divide_fault = fault_reg;

    // a faulted result carries zero values
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && divide_fault) |-> (estimate == '0 && error_estimate == '0))
        else $error("faulted result with non-zero values");

    // the block is free again right after a result beat
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("busy after result beat");

    // work begins only on an accepted query
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == REQ_EVAL)))
        else $error("busy without a query beat");

endmodule

FILE: hdl/nev_muldiv.sv
// nev_muldiv: serial multiply then restoring divide, |a|*|b|/|d| with sign and saturation
// one multiplier bit per mul_step, one quotient bit per div_step
// depends on nev_pkg
module nev_muldiv #(
    parameter int VW = nev_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  nev_pkg::cell_ctrl_t        ctrl,
    input  logic [VW-1:0]              amag,
    input  logic [nev_pkg::H_W-1:0]    bmag,
    input  logic [nev_pkg::H_W-1:0]    dmag,
    input  logic                       neg,
    output logic signed [VW-1:0]       result
);
    import nev_pkg::*;

    localparam int PW = VW + H_W - 1;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    logic [VW-1:0]  a_reg;
    logic [H_W-1:0] b_reg;
    logic [H_W-1:0] d_reg;
    logic           neg_reg;
    logic [PW-1:0]  prod_reg;
    logic [H_W-1:0] rem_reg;
    logic [VW-1:0]  q_reg;
    logic           ovf_reg;

    logic [H_W:0]   trial;
    logic           qbit;
    logic           sat;

    // trial subtraction for one quotient bit
    always_comb
    begin
        trial = {rem_reg, prod_reg[PW-1]};
        qbit  = (trial >= {1'b0, d_reg});
    end

    // operand capture, shift-add product, long division
    always_ff @(posedge clk)
    begin
        if (ctrl.op_start)
        begin
            a_reg    <= amag;
            b_reg    <= bmag;
            d_reg    <= dmag;
            neg_reg  <= neg;
            prod_reg <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (ctrl.mul_step)
        begin
            prod_reg <= (prod_reg << 1) + (b_reg[H_W-1] ? PW'(a_reg) : PW'(0));
            b_reg    <= b_reg << 1;
        end
        else if (ctrl.div_step)
        begin
            rem_reg  <= qbit ? H_W'(trial - {1'b0, d_reg}) : H_W'(trial);
            prod_reg <= prod_reg << 1;
            ovf_reg  <= ovf_reg | q_reg[VW-1];
            q_reg    <= {q_reg[VW-2:0], qbit};
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        sat = ovf_reg | q_reg[VW-1];
        if (neg_reg)
        begin
            result = sat ? VMIN : -q_reg;
        end
        else
        begin
            result = sat ? VMAX : q_reg;
        end
    end

endmodule

FILE: hdl/nev_cell.sv
// nev_cell: one tableau cell holding a tabulated point, its C and D entries and a probe
// the probe shifts down the chain so cell i sees abscissa i+k after k shifts
// depends on nev_pkg and nev_muldiv
module nev_cell #(
    parameter int VW = nev_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nev_pkg::cell_ctrl_t               ctrl,
    input  logic                              wr_en,
    input  logic signed [nev_pkg::DATA_W-1:0] wr_x,
    input  logic signed [nev_pkg::DATA_W-1:0] wr_y,
    input  logic signed [nev_pkg::DATA_W-1:0] qx,
    input  logic                              cell_valid,
    input  logic signed [nev_pkg::DATA_W-1:0] probe_in,
    input  logic                              probe_vin,
    input  logic signed [VW-1:0]              c_in,
    output logic signed [nev_pkg::DATA_W-1:0] xa,
    output logic signed [nev_pkg::DATA_W-1:0] probe,
    output logic                              probe_v,
    output logic signed [VW-1:0]              c_out,
    output logic signed [VW-1:0]              d_out,
    output logic                              hit
);
    import nev_pkg::*;

    localparam int EW = (VW > DATA_W) ? VW : DATA_W;
    localparam logic signed [EW-1:0] VMAX_E = signed'({{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}});
    localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;

    logic signed [DATA_W-1:0] xa_reg;
    logic signed [DATA_W-1:0] ya_reg;
    logic signed [DATA_W-1:0] probe_reg;
    logic                     probe_v_reg;
    logic signed [VW-1:0]     c_reg;
    logic signed [VW-1:0]     d_reg;

    logic signed [EW-1:0]     ya_e;
    logic signed [VW-1:0]     ya_clamp;
    logic signed [VW:0]       w_wide;
    logic signed [VW-1:0]     w;
    logic [VW-1:0]            w_mag;
    logic signed [H_W-1:0]    h_o;
    logic signed [H_W-1:0]    h_p;
    logic signed [H_W-1:0]    den;
    logic [H_W-1:0]           h_o_mag;
    logic [H_W-1:0]           h_p_mag;
    logic [H_W-1:0]           den_mag;
    logic signed [VW-1:0]     res_d;
    logic signed [VW-1:0]     res_c;

    // ordinate clamped to the working width
    always_comb
    begin
        ya_e = EW'(ya_reg);
        if (ya_e > VMAX_E)
        begin
            ya_clamp = VMAX_E[VW-1:0];
        end
        else if (ya_e < VMIN_E)
        begin
            ya_clamp = VMIN_E[VW-1:0];
        end
        else
        begin
            ya_clamp = ya_e[VW-1:0];
        end
    end

    // operands of the update: w = c[i+1] - d[i] saturated, offsets and denominator
    always_comb
    begin
        w_wide = {c_in[VW-1], c_in} - {d_reg[VW-1], d_reg};
        if (w_wide[VW] != w_wide[VW-1])
        begin
            w = w_wide[VW] ? VMIN_E[VW-1:0] : VMAX_E[VW-1:0];
        end
        else
        begin
            w = w_wide[VW-1:0];
        end
        w_mag   = w[VW-1] ? -w : w;
        h_o     = {xa_reg[DATA_W-1], xa_reg} - {qx[DATA_W-1], qx};
        h_p     = {probe_reg[DATA_W-1], probe_reg} - {qx[DATA_W-1], qx};
        den     = {xa_reg[DATA_W-1], xa_reg} - {probe_reg[DATA_W-1], probe_reg};
        h_o_mag = h_o[H_W-1] ? -h_o : h_o;
        h_p_mag = h_p[H_W-1] ? -h_p : h_p;
        den_mag = den[H_W-1] ? -den : den;
    end

    // d update uses the far offset, c update the near one
    nev_muldiv #(.VW(VW)) u_mul_d (
        .clk    (clk),
        .ctrl   (ctrl),
        .amag   (w_mag),
        .bmag   (h_p_mag),
        .dmag   (den_mag),
        .neg    (w[VW-1] ^ h_p[H_W-1] ^ den[H_W-1]),
        .result (res_d)
    );

    nev_muldiv #(.VW(VW)) u_mul_c (
        .clk    (clk),
        .ctrl   (ctrl),
        .amag   (w_mag),
        .bmag   (h_o_mag),
        .dmag   (den_mag),
        .neg    (w[VW-1] ^ h_o[H_W-1] ^ den[H_W-1]),
        .result (res_c)
    );

    // probe valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_v_reg <= 1'b0;
        end
        else if (ctrl.probe_load)
        begin
            probe_v_reg <= cell_valid;
        end
        else if (ctrl.probe_shift)
        begin
            probe_v_reg <= probe_vin;
        end
    end

    // point storage, probe and tableau entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xa_reg <= wr_x;
            ya_reg <= wr_y;
        end
        if (ctrl.probe_load)
        begin
            probe_reg <= xa_reg;
        end
        else if (ctrl.probe_shift)
        begin
            probe_reg <= probe_in;
        end
        if (ctrl.tab_init)
        begin
            c_reg <= ya_clamp;
            d_reg <= ya_clamp;
        end
        else if (ctrl.commit && probe_v_reg)
        begin
            c_reg <= res_c;
            d_reg <= res_d;
        end
    end

    assign xa      = xa_reg;
    assign probe   = probe_reg;
    assign probe_v = probe_v_reg;
    assign c_out   = c_reg;
    assign d_out   = d_reg;
    assign hit     = cell_valid & probe_v_reg & (xa_reg == probe_reg);

endmodule

FILE: test/testbench.sv
// testbench for neville_polynomial_interpolator_core: loads tabulated points, runs queries
// and checks every result against a fixed-point neville predictor held in a scoreboard
// depends on nev_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import nev_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] estimate;
        logic signed [DATA_W-1:0] error_estimate;
        logic                     divide_fault;
    } interp_result_t;

    // scoreboard: own copy of the point table and point count, queue of pending answers
    class interp_scoreboard;
        longint         abscissa[NPTS];
        longint         ordinate[NPTS];
        int unsigned    point_count;
        interp_result_t pending[$];
        int             errors;

        function new();
            point_count = NP_RESET;
            errors = 0;
            foreach (abscissa[i])
            begin
                abscissa[i] = 0;
                ordinate[i] = 0;
            end
        endfunction

        static function longint clampv(longint a);
            if (a > VMAX) return VMAX;
            if (a < VMIN) return VMIN;
            return a;
        endfunction

        // w * h / den with exact product and truncated, saturated quotient
        static function longint scaled_ratio(longint w, longint h, longint den);
            logic [127:0] am;
            logic [127:0] bm;
            logic [127:0] dm;
            logic [127:0] q;
            bit neg;
            am = (w < 0) ? 128'(-w) : 128'(w);
            bm = (h < 0) ? 128'(-h) : 128'(h);
            dm = (den < 0) ? 128'(-den) : 128'(den);
            neg = ((w < 0) != (h < 0)) != (den < 0);
            q = (am * bm) / dm;
            if (q > 128'(VMAX)) return neg ? VMIN : VMAX;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_input(logic rt, logic [IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] xv,
                                 logic signed [DATA_W-1:0] yv);
            longint c[NPTS];
            longint d[NPTS];
            longint x;
            longint y;
            longint dy;
            longint best;
            longint diff;
            longint w;
            longint den;
            int n;
            int p;
            interp_result_t r;
            if (rt == REQ_LOAD)
            begin
                abscissa[idx] = xv;
                ordinate[idx] = yv;
                return;
            end
            n = point_count;
            if (n < 1) n = 1;
            if (n > NPTS) n = NPTS;
            x = xv;
            r.estimate = '0;
            r.error_estimate = '0;
            r.divide_fault = 1'b0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (abscissa[i] == abscissa[j]) r.divide_fault = 1'b1;
            if (r.divide_fault)
            begin
                pending.push_back(r);
                return;
            end
            // nearest abscissa, first one wins a tie
            p = 0;
            best = abscissa[0] - x;
            if (best < 0) best = -best;
            for (int i = 0; i < n; i++)
            begin
                diff = abscissa[i] - x;
                if (diff < 0) diff = -diff;
                if (diff < best)
                begin
                    best = diff;
                    p = i;
                end
                c[i] = clampv(ordinate[i]);
                d[i] = c[i];
            end
            y = c[p];
            dy = 0;
            // tableau columns
            for (int m = 1; m < n; m++)
            begin
                for (int i = 0; i < n - m; i++)
                begin
                    den = abscissa[i] - abscissa[i + m];
                    w = clampv(c[i + 1] - d[i]);
                    d[i] = scaled_ratio(w, abscissa[i + m] - x, den);
                    c[i] = scaled_ratio(w, abscissa[i] - x, den);
                end
                if (2 * p < n - m)
                    dy = c[p];
                else
                begin
                    p--;
                    dy = d[p];
                end
                y = clampv(y + dy);
            end
            r.estimate = y[DATA_W-1:0];
            r.error_estimate = dy[DATA_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] est,
                                   logic signed [DATA_W-1:0] err, logic flt);
            interp_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with no query pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (est !== e.estimate)
            begin
                $error("estimate: expected %0d, got %0d", e.estimate, est);
                errors++;
            end
            if (err !== e.error_estimate)
            begin
                $error("error_estimate: expected %0d, got %0d", e.error_estimate, err);
                errors++;
            end
            if (flt !== e.divide_fault)
            begin
                $error("divide_fault: expected %0d, got %0d", e.divide_fault, flt);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic [IDX_W-1:0]         point_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [NP_W-1:0]          cfg_data;
    logic                     result_valid;
    logic signed [DATA_W-1:0] estimate;
    logic signed [DATA_W-1:0] error_estimate;
    logic                     divide_fault;

    interp_scoreboard sb;
    int item_count;

    neville_polynomial_interpolator_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .point_index    (point_index),
        .x_value        (x_value),
        .y_value        (y_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .estimate       (estimate),
        .error_estimate (error_estimate),
        .divide_fault   (divide_fault)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(estimate, error_estimate, divide_fault);
    end

    // idle gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // one request beat, waits for acceptance
    task automatic send_beat(logic rt, logic [IDX_W-1:0] idx,
                             logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= rt;
        point_index <= idx;
        x_value     <= xv;
        y_value     <= yv;
        do
            @(posedge clk);
        while (busy);
        sb.note_input(rt, idx, xv, yv);
        item_count++;
    endtask

    // wait until every pending result is back and the core is quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_points(logic [NP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.point_count = v;
    endtask

    // mostly small abscissae and ordinates, sometimes the full range
    function automatic logic signed [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        if (r < 90) return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        return $urandom;
    endfunction

    initial
    begin
        sb = new();
        item_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_LOAD;
        point_index = '0;
        x_value = '0;
        y_value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill every slot, extremes of the ordinate
        for (int i = 0; i < NPTS; i++)
            send_beat(REQ_LOAD, IDX_W'(i), (i - 8) * 32'sh0001_0000,
                      (i == 0) ? 32'sh7fff_ffff : (i == 1) ? 32'sh8000_0000 :
                      $signed(i * 32'sh0000_3000));
        send_beat(REQ_EVAL, 4'hf, 32'sh7fff_ffff, 32'sh8000_0000);
        send_beat(REQ_EVAL, 4'h0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_beat(REQ_EVAL, 4'h5, 32'shfff9_8000, '0);
        drain();
        // single point, zero count, oversized count, full table
        write_points(5'd1);
        send_beat(REQ_EVAL, '0, 32'sh0000_1234, '0);
        drain();
        write_points(5'd0);
        send_beat(REQ_EVAL, '0, 32'shfff8_0000, '0);
        drain();
        write_points(5'd31);
        send_beat(REQ_EVAL, '0, 32'sh0000_8000, '0);
        drain();
        write_points(5'd16);
        send_beat(REQ_EVAL, '0, 32'sh0007_0000, '0);
        // coincident abscissae
        send_beat(REQ_LOAD, 4'd3, 32'shfff9_0000, 32'sh0001_0000);
        send_beat(REQ_EVAL, '0, '0, '0);
        send_beat(REQ_LOAD, 4'd3, 32'shfffb_0000, 32'sh0001_0000);
        drain();

        // random phases, each with its own point count
        while (item_count < 750)
        begin
            int r;
            int n;
            r = $urandom_range(99);
            if (r < 70) n = $urandom_range(6, 1);
            else if (r < 80) n = $urandom_range(12, 7);
            else if (r < 87) n = 16;
            else if (r < 92) n = 0;
            else if (r < 96) n = $urandom_range(31, 17);
            else n = 2;
            write_points(NP_W'(n));
            repeat ($urandom_range(40, 20))
            begin
                if ($urandom_range(99) < 55)
                    send_beat(REQ_LOAD, IDX_W'($urandom), rand_value(), rand_value());
                else
                    send_beat(REQ_EVAL, IDX_W'($urandom), rand_value(), $urandom);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/nev_pkg.sv
hdl/nev_muldiv.sv
hdl/nev_cell.sv
hdl/neville_polynomial_interpolator_core.sv
test/testbench.sv
